// ===== hdl/run_length_histogram_core_defines.svh =====
// Assertion macros for the run-length histogram checker.
`ifndef RUN_LENGTH_HISTOGRAM_CORE_DEFINES_SVH
`define RUN_LENGTH_HISTOGRAM_CORE_DEFINES_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define RLH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Concurrent assertion that also holds while reset is asserted.
`define RLH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/rlh_pkg.sv =====
// Shared types, codes and defaults of the run-length histogram core.
package rlh_pkg;

  // Default sizes.
  localparam int unsigned DEF_BINS         = 256;
  localparam int unsigned DEF_MAX_ROW_BITS = 4096;
  localparam int unsigned DEF_COUNT_BITS   = 32;

  // Fixed field widths.
  localparam int unsigned OP_W  = 2;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned CFG_W = 9;
  localparam int unsigned OUT_W = 32;

  // Operation codes of an input item.
  localparam logic [OP_W-1:0] OP_COUNT = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Reset value of the bins-in-use register.
  localparam logic [CFG_W-1:0] BINS_IN_USE_RST = 9'd256;

  // What the memory stage does with a bin.
  typedef enum logic [1:0] {
    KIND_INC,
    KIND_READ,
    KIND_CLEAR
  } rlh_kind_e;

  // Bin access request from the run tracker to the memory stage.
  typedef struct packed {
    logic      vld;
    rlh_kind_e kind;
    logic      sel;   // 0 ON-run histogram, 1 OFF-run histogram
    logic      zero;  // read of a bin that does not exist returns zero
  } rlh_ctl_t;

endpackage

// ===== hdl/run_length_histogram_core.sv =====
// Top level of the binary run-length histogram core.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   operation, pixel_bit, row_start,
//                                                 bin_index, which_histogram
//   out      output     out_valid_o / out_ready_i bin_count, bin_echo
//   cfg      input      cfg_valid_i / cfg_ready_o bins_in_use (cfg_data_i)
//
// One item per cycle while the memory is not clearing and the queue has room;
// a read result is registered in the request stage and again in the result queue.
// The rate is set by the single read-modify-write path of the histogram memory,
// which forwards the previous write when two items hit the same bin. After reset
// all 2 * 2**clog2(BINS) entries (512 by default) are cleared; in_ready_o stays low
// during that pass while configuration writes are taken. A stalled output keeps the
// input open until the queue, counting a read still in flight, holds two results.
module run_length_histogram_core #(
  parameter int unsigned BINS         = rlh_pkg::DEF_BINS,
  parameter int unsigned MAX_ROW_BITS = rlh_pkg::DEF_MAX_ROW_BITS,
  parameter int unsigned COUNT_BITS   = rlh_pkg::DEF_COUNT_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [rlh_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [rlh_pkg::OP_W-1:0]  operation_i,
  input  logic                      pixel_bit_i,
  input  logic                      row_start_i,
  input  logic [rlh_pkg::IDX_W-1:0] bin_index_i,
  input  logic                      which_histogram_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rlh_pkg::OUT_W-1:0] bin_count_o,
  output logic [rlh_pkg::IDX_W-1:0] bin_echo_o
);
  import rlh_pkg::*;

  localparam int unsigned AW = $clog2(BINS);

  rlh_ctl_t              req_ctl;
  logic [AW-1:0]         req_addr;
  logic                  accept;
  logic                  busy;
  logic                  rd_vld;
  logic [COUNT_BITS-1:0] rd_count;
  logic [IDX_W-1:0]      rd_echo;
  logic [OUT_W-1:0]      rd_count_sat;
  logic [1:0]            level;
  logic                  pop;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // Accept only after the clear pass and while the queue can take every read in flight.
  assign in_ready_o = !busy &&
                      (({1'b0, level} + 3'(rd_vld)) <= (3'd1 + 3'(pop)));

  rlh_run_tracker #(
    .BINS         (BINS),
    .MAX_ROW_BITS (MAX_ROW_BITS)
  ) u_tracker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .accept_i          (accept),
    .operation_i       (operation_i),
    .pixel_bit_i       (pixel_bit_i),
    .row_start_i       (row_start_i),
    .bin_index_i       (bin_index_i),
    .which_histogram_i (which_histogram_i),
    .ctl_o             (req_ctl),
    .addr_o            (req_addr)
  );

  rlh_bin_mem #(
    .BINS       (BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_ctl_i  (req_ctl),
    .req_addr_i (req_addr),
    .req_echo_i (bin_index_i),
    .busy_o     (busy),
    .rd_vld_o   (rd_vld),
    .rd_count_o (rd_count),
    .rd_echo_o  (rd_echo)
  );

  // Counts wider than the output field saturate at its maximum.
  if (COUNT_BITS > OUT_W) begin : g_sat
    assign rd_count_sat = (|rd_count[COUNT_BITS-1:OUT_W]) ? '1 : rd_count[OUT_W-1:0];
  end else begin : g_ext
    assign rd_count_sat = OUT_W'(rd_count);
  end

  rlh_out_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (rd_vld),
    .push_count_i (rd_count_sat),
    .push_echo_i  (rd_echo),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .bin_count_o  (bin_count_o),
    .bin_echo_o   (bin_echo_o),
    .level_o      (level)
  );

endmodule

// ===== hdl/rlh_run_tracker.sv =====
// Run colour and length tracking, operation decode and the bins-in-use register.
module rlh_run_tracker #(
  parameter int unsigned BINS         = rlh_pkg::DEF_BINS,
  parameter int unsigned MAX_ROW_BITS = rlh_pkg::DEF_MAX_ROW_BITS,
  localparam int unsigned AW          = $clog2(BINS),
  localparam int unsigned LEN_W       = $clog2(MAX_ROW_BITS + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic [rlh_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      accept_i,
  input  logic [rlh_pkg::OP_W-1:0]  operation_i,
  input  logic                      pixel_bit_i,
  input  logic                      row_start_i,
  input  logic [rlh_pkg::IDX_W-1:0] bin_index_i,
  input  logic                      which_histogram_i,
  output rlh_pkg::rlh_ctl_t         ctl_o,
  output logic [AW-1:0]             addr_o
);
  import rlh_pkg::*;

  logic             colour_q, colour_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [CFG_W-1:0] bins_q;
  logic             col0;
  logic [LEN_W-1:0] len0;
  logic             change;
  logic             fits;

  // Bins-in-use register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q <= BINS_IN_USE_RST;
    end else if (cfg_valid_i) begin
      bins_q <= cfg_data_i;
    end
  end

  // Run state; a row start behaves as an OFF run of length zero.
  always_comb begin
    col0   = row_start_i ? 1'b0 : colour_q;
    len0   = row_start_i ? '0 : len_q;
    change = (pixel_bit_i != col0);
    fits   = (32'(len0) < 32'(bins_q)) && (32'(len0) < BINS);
  end

  // Decode the item into a bin request and the next run state.
  always_comb begin
    colour_d = colour_q;
    len_d    = len_q;
    ctl_o    = '0;
    addr_o   = AW'(bin_index_i);
    unique case (operation_i)
      OP_COUNT: begin
        colour_d = pixel_bit_i;
        if (change) begin
          len_d = LEN_W'(1);
        end else if (32'(len0) < MAX_ROW_BITS) begin
          len_d = len0 + LEN_W'(1);
        end else begin
          len_d = len0;
        end
        ctl_o.vld  = change && fits;
        ctl_o.kind = KIND_INC;
        ctl_o.sel  = ~col0;
        addr_o     = AW'(len0);
      end
      OP_READ: begin
        ctl_o.vld  = 1'b1;
        ctl_o.kind = KIND_READ;
        ctl_o.sel  = which_histogram_i;
        ctl_o.zero = (32'(bin_index_i) >= BINS);
      end
      OP_CLEAR: begin
        ctl_o.vld  = (32'(bin_index_i) < BINS);
        ctl_o.kind = KIND_CLEAR;
        ctl_o.sel  = which_histogram_i;
      end
      default: begin
      end
    endcase
    if (!accept_i) begin
      colour_d  = colour_q;
      len_d     = len_q;
      ctl_o.vld = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_q <= 1'b0;
      len_q    <= '0;
    end else begin
      colour_q <= colour_d;
      len_q    <= len_d;
    end
  end

endmodule

// ===== hdl/rlh_bin_mem.sv =====
// Histogram memory with read-modify-write, write forwarding and the clear pass.
module rlh_bin_mem #(
  parameter int unsigned BINS       = rlh_pkg::DEF_BINS,
  parameter int unsigned COUNT_BITS = rlh_pkg::DEF_COUNT_BITS,
  localparam int unsigned AW        = $clog2(BINS),
  localparam int unsigned MAW       = AW + 1,
  localparam int unsigned DEPTH     = 2 ** MAW
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rlh_pkg::rlh_ctl_t         req_ctl_i,
  input  logic [AW-1:0]             req_addr_i,
  input  logic [rlh_pkg::IDX_W-1:0] req_echo_i,
  output logic                      busy_o,
  output logic                      rd_vld_o,
  output logic [COUNT_BITS-1:0]     rd_count_o,
  output logic [rlh_pkg::IDX_W-1:0] rd_echo_o
);
  import rlh_pkg::*;

  // Both histograms share one memory: the histogram select is the top address bit.
  logic [COUNT_BITS-1:0] mem_q [DEPTH];
  logic [COUNT_BITS-1:0] rd_data_q;

  logic                  clr_q;
  logic [MAW-1:0]        clr_ptr_q;

  rlh_ctl_t              s1_ctl_q;
  logic [MAW-1:0]        s1_idx_q;
  logic [IDX_W-1:0]      s1_echo_q;

  logic                  lw_vld_q;
  logic [MAW-1:0]        lw_idx_q;
  logic [COUNT_BITS-1:0] lw_data_q;

  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] nxt;
  logic                  item_we;
  logic                  we;
  logic [MAW-1:0]        wa;
  logic [COUNT_BITS-1:0] wd;

  // Clear pass after reset, one entry per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_ptr_q <= '0;
    end else if (clr_q) begin
      clr_ptr_q <= clr_ptr_q + MAW'(1);
      if (clr_ptr_q == MAW'(DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // Request stage: issue the read and carry the request along.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
    end else begin
      s1_ctl_q <= req_ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q  <= {req_ctl_i.sel, req_addr_i};
    s1_echo_q <= req_echo_i;
    if (req_ctl_i.vld) begin
      rd_data_q <= mem_q[{req_ctl_i.sel, req_addr_i}];
    end
  end

  // Modify stage: the write of the previous cycle is not yet in the read data.
  always_comb begin
    cur = (lw_vld_q && (lw_idx_q == s1_idx_q)) ? lw_data_q : rd_data_q;
    case (s1_ctl_q.kind)
      KIND_INC:   nxt = (&cur) ? cur : cur + COUNT_BITS'(1);
      KIND_CLEAR: nxt = '0;
      default:    nxt = cur;
    endcase
    item_we = s1_ctl_q.vld && (s1_ctl_q.kind != KIND_READ);
    we      = clr_q || item_we;
    wa      = clr_q ? clr_ptr_q : s1_idx_q;
    wd      = clr_q ? '0 : nxt;
  end

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
  end

  // Last write, registered for forwarding.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_vld_q <= 1'b0;
    end else begin
      lw_vld_q <= item_we;
    end
  end

  always_ff @(posedge clk_i) begin
    lw_idx_q  <= s1_idx_q;
    lw_data_q <= nxt;
  end

  // Read result.
  assign busy_o     = clr_q;
  assign rd_vld_o   = s1_ctl_q.vld && (s1_ctl_q.kind == KIND_READ);
  assign rd_count_o = s1_ctl_q.zero ? '0 : cur;
  assign rd_echo_o  = s1_echo_q;

endmodule

// ===== hdl/rlh_out_fifo.sv =====
// Two-entry result queue between the memory stage and the output channel.
module rlh_out_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [rlh_pkg::OUT_W-1:0] push_count_i,
  input  logic [rlh_pkg::IDX_W-1:0] push_echo_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rlh_pkg::OUT_W-1:0] bin_count_o,
  output logic [rlh_pkg::IDX_W-1:0] bin_echo_o,
  output logic [1:0]                level_o
);
  import rlh_pkg::*;

  logic [OUT_W-1:0] count_q [2];
  logic [IDX_W-1:0] echo_q  [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       level_q;
  logic             pop;

  assign out_valid_o = (level_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      level_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      level_q <= level_q + 2'(push_i) - 2'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      count_q[wr_ptr_q] <= push_count_i;
      echo_q[wr_ptr_q]  <= push_echo_i;
    end
  end

  assign bin_count_o = count_q[rd_ptr_q];
  assign bin_echo_o  = echo_q[rd_ptr_q];
  assign level_o     = level_q;

endmodule

// ===== hdl/rlh_checker.sv =====
// Port-level assertions for the run-length histogram core and their bind.
`include "run_length_histogram_core_defines.svh"

module rlh_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o,
  input logic [rlh_pkg::CFG_W-1:0] cfg_data_i,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic [rlh_pkg::OP_W-1:0]  operation_i,
  input logic                      pixel_bit_i,
  input logic                      row_start_i,
  input logic [rlh_pkg::IDX_W-1:0] bin_index_i,
  input logic                      which_histogram_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [rlh_pkg::OUT_W-1:0] bin_count_o,
  input logic [rlh_pkg::IDX_W-1:0] bin_echo_o
);
  import rlh_pkg::*;

  // A stalled result holds its value.
  `RLH_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(bin_count_o) && $stable(bin_echo_o), "output item changed while stalled")

  // Every new result comes from an accepted read item, with its index.
  `RLH_ASSERT(a_out_from_read, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && operation_i == OP_READ, 2) && bin_echo_o == $past(bin_index_i, 2), "result without a matching read item")

  // No result in the cycle after reset has been seen.
  `RLH_ASSERT_ALWAYS(a_out_reset, !rst_ni |=> !out_valid_o, "output valid after reset")

  // The memory clear pass keeps the input closed right after reset.
  `RLH_ASSERT_ALWAYS(a_clear_pass, !rst_ni |=> !in_ready_o, "input open before the clear pass")

endmodule

bind run_length_histogram_core rlh_checker u_rlh_checker (.*);

// ===== tb/run_length_histogram_checker.sv =====
// Checker for the run-length histogram core: predicts bin reads and compares them.
module run_length_histogram_checker #(
  parameter int unsigned BINS         = rlh_pkg::DEF_BINS,
  parameter int unsigned MAX_ROW_BITS = rlh_pkg::DEF_MAX_ROW_BITS,
  parameter int unsigned COUNT_BITS   = rlh_pkg::DEF_COUNT_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [rlh_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [rlh_pkg::OP_W-1:0]  operation_i,
  input  logic                      pixel_bit_i,
  input  logic                      row_start_i,
  input  logic [rlh_pkg::IDX_W-1:0] bin_index_i,
  input  logic                      which_histogram_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [rlh_pkg::OUT_W-1:0] bin_count_i,
  input  logic [rlh_pkg::IDX_W-1:0] bin_echo_i,
  output int unsigned               pending_o,
  output int unsigned               errors_o
);

  localparam int unsigned LEN_W = $clog2(MAX_ROW_BITS + 1);
  localparam int unsigned AW    = $clog2(BINS);

  // One expected read result.
  typedef struct packed {
    logic [rlh_pkg::OUT_W-1:0] count;
    logic [rlh_pkg::IDX_W-1:0] echo;
  } bin_readout_t;

  // Predicted state of the block.
  logic                      run_colour;
  logic [LEN_W-1:0]          run_length;
  logic [rlh_pkg::CFG_W-1:0] bins_in_use;
  logic [COUNT_BITS-1:0]     on_hist [BINS];
  logic [COUNT_BITS-1:0]     off_hist [BINS];
  bin_readout_t              expected_reads [$];
  int unsigned               mismatches = 0;

  assign errors_o = mismatches;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Adds one to a bin for a finished run, if the run length is in use.
  function automatic void add_run(input logic off_sel, input logic [LEN_W-1:0] len);
    int unsigned active;
    active = (bins_in_use < BINS) ? bins_in_use : BINS;
    if (len < active && len < BINS) begin
      if (off_sel) begin
        if (off_hist[AW'(len)] != '1) off_hist[AW'(len)]++;
      end else begin
        if (on_hist[AW'(len)] != '1) on_hist[AW'(len)]++;
      end
    end
  endfunction

  // Advances the prediction by one accepted item.
  function automatic void take_item(input logic [rlh_pkg::OP_W-1:0] op, input logic pix,
                                    input logic rs, input logic [rlh_pkg::IDX_W-1:0] idx,
                                    input logic sel);
    logic [63:0]  c;
    bin_readout_t r;
    case (op)
      rlh_pkg::OP_COUNT: begin
        if (rs) begin
          run_colour = 1'b0;
          run_length = '0;
        end
        // A colour change closes the run: ON runs go to the ON histogram.
        if (pix != run_colour) begin
          add_run(!run_colour, run_length);
          run_colour = pix;
          run_length = '0;
        end
        if (run_length < MAX_ROW_BITS) run_length++;
      end
      rlh_pkg::OP_READ: begin
        c = '0;
        if (idx < BINS) c = sel ? 64'(off_hist[idx]) : 64'(on_hist[idx]);
        if (c > 64'hFFFF_FFFF) c = 64'hFFFF_FFFF;
        r.count = c[rlh_pkg::OUT_W-1:0];
        r.echo  = idx;
        expected_reads.push_back(r);
      end
      rlh_pkg::OP_CLEAR: begin
        if (idx < BINS) begin
          if (sel) off_hist[idx] = '0;
          else on_hist[idx] = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // Returns the prediction to its reset state.
  function automatic void reset_prediction();
    for (int b = 0; b < BINS; b++) begin
      on_hist[b]  = '0;
      off_hist[b] = '0;
    end
    run_colour  = 1'b0;
    run_length  = '0;
    bins_in_use = rlh_pkg::BINS_IN_USE_RST;
    expected_reads.delete();
  endfunction

  // Watch all three channels and compare each result with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    bin_readout_t want;
    if (!rst_ni) begin
      reset_prediction();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) bins_in_use = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_reads.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: count %0d, bin %0d",
                                    bin_count_i, bin_echo_i));
        end else begin
          want = expected_reads.pop_front();
          if (bin_count_i !== want.count)
            report_mismatch($sformatf("bin_count for bin %0d: got %0d, expected %0d",
                                      want.echo, bin_count_i, want.count));
          if (bin_echo_i !== want.echo)
            report_mismatch($sformatf("bin_echo: got %0d, expected %0d",
                                      bin_echo_i, want.echo));
        end
      end
      if (in_valid_i && in_ready_i)
        take_item(operation_i, pixel_bit_i, row_start_i, bin_index_i, which_histogram_i);
      pending_o <= expected_reads.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the run-length histogram core: stimulus, idling and the verdict.
module tb_top;

  localparam int unsigned CLK_PERIOD   = 20;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned IDLE_PCT     = 38;

  // Operation code that the block ignores.
  localparam logic [rlh_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  logic                      clk             = 1'b0;
  logic                      rst_n           = 1'b0;
  logic                      cfg_valid       = 1'b0;
  logic                      cfg_ready;
  logic [rlh_pkg::CFG_W-1:0] cfg_data        = '0;
  logic                      in_valid        = 1'b0;
  logic                      in_ready;
  logic [rlh_pkg::OP_W-1:0]  operation       = rlh_pkg::OP_COUNT;
  logic                      pixel_bit       = 1'b0;
  logic                      row_start       = 1'b0;
  logic [rlh_pkg::IDX_W-1:0] bin_index       = '0;
  logic                      which_histogram = 1'b0;
  logic                      out_valid;
  logic                      out_ready       = 1'b0;
  logic [rlh_pkg::OUT_W-1:0] bin_count;
  logic [rlh_pkg::IDX_W-1:0] bin_echo;

  int unsigned pending_reads;
  int unsigned mismatch_total;
  int unsigned items_made    = 0;
  bit          calm          = 1'b0;
  bit          hold_request  = 1'b0;

  run_length_histogram_core dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .operation_i       (operation),
    .pixel_bit_i       (pixel_bit),
    .row_start_i       (row_start),
    .bin_index_i       (bin_index),
    .which_histogram_i (which_histogram),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .bin_count_o       (bin_count),
    .bin_echo_o        (bin_echo)
  );

  run_length_histogram_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .operation_i       (operation),
    .pixel_bit_i       (pixel_bit),
    .row_start_i       (row_start),
    .bin_index_i       (bin_index),
    .which_histogram_i (which_histogram),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .bin_count_i       (bin_count),
    .bin_echo_i        (bin_echo),
    .pending_o         (pending_reads),
    .errors_o          (mismatch_total)
  );

  // Clock generation.
  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Watchdog for a hung run.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Simulation FAILED");
    $finish;
  end

  // Result receiver: random stalls, a counted hold-off on request, none while calm.
  initial begin
    int unsigned held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        held = HOLD_CYCLES;
      end
      if (held != 0) begin
        out_ready <= 1'b0;
        held--;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offer one item, with a random gap first, and wait until it is taken.
  task automatic offer(input logic [rlh_pkg::OP_W-1:0] op, input logic pix, input logic rs,
                       input logic [rlh_pkg::IDX_W-1:0] idx, input logic sel);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    operation       <= op;
    pixel_bit       <= pix;
    row_start       <= rs;
    bin_index       <= idx;
    which_histogram <= sel;
    do @(posedge clk); while (!in_ready);
    items_made++;
  endtask

  // Pixel item; the bin fields are ignored by the block and get random values.
  task automatic offer_pixel(input logic pix, input logic rs);
    offer(rlh_pkg::OP_COUNT, pix, rs, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // Bin access item; the pixel fields are ignored and get random values.
  task automatic offer_access(input logic [rlh_pkg::OP_W-1:0] op,
                              input logic [rlh_pkg::IDX_W-1:0] idx, input logic sel);
    offer(op, 1'($urandom_range(1)), 1'($urandom_range(1)), idx, sel);
  endtask

  // A run of one colour inside the current row.
  task automatic offer_run(input logic pix, input int unsigned len);
    repeat (len) offer_pixel(pix, 1'b0);
  endtask

  // Random read, clear or ignored item, mostly aimed at the low bins.
  task automatic offer_bin_op();
    logic [rlh_pkg::IDX_W-1:0] idx;
    int unsigned               pick;
    idx  = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 70) offer_access(rlh_pkg::OP_READ, idx, 1'($urandom_range(1)));
    else if (pick < 92) offer_access(rlh_pkg::OP_CLEAR, idx, 1'($urandom_range(1)));
    else offer_access(OP_UNUSED, idx, 1'($urandom_range(1)));
  endtask

  // One row of random runs with bin operations mixed in and a stray row start now and then.
  task automatic offer_row(input int unsigned max_len);
    int unsigned len;
    int unsigned flip_pct;
    logic        colour;
    len      = $urandom_range(max_len, 1);
    flip_pct = ($urandom_range(7) == 0) ? 3 : 35;
    colour   = 1'($urandom_range(1));
    for (int unsigned k = 0; k < len; k++) begin
      if (k != 0 && $urandom_range(99) < flip_pct) colour = ~colour;
      if ($urandom_range(99) < 20) offer_bin_op();
      offer_pixel(colour, (k == 0) ? 1'b1 : ($urandom_range(29) == 0));
    end
  endtask

  // Random rows until about the given number of items has gone in.
  task automatic random_rows(input int unsigned count, input int unsigned max_len);
    items_made = 0;
    while (items_made < count) offer_row(max_len);
  endtask

  // Stop offering, wait until every read has come back, then let the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reads != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the bins-in-use register while the block is idle.
  task automatic write_bins(input logic [rlh_pkg::CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Main stimulus sequence.
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // All-ones setting acts as the full bin count.
    write_bins(9'h1FF);

    // Directed items: empty bins, a row that starts with a one, the dropped run at
    // the end of a row, back-to-back update and read of one bin, clears, ignored code.
    offer_access(rlh_pkg::OP_READ, 8'd0, 1'b0);
    offer_access(rlh_pkg::OP_READ, 8'd255, 1'b1);
    offer_pixel(1'b1, 1'b1);
    offer_pixel(1'b1, 1'b0);
    offer_pixel(1'b0, 1'b0);
    offer_pixel(1'b0, 1'b0);
    offer_pixel(1'b0, 1'b0);
    offer_pixel(1'b1, 1'b0);
    offer_pixel(1'b0, 1'b1);
    offer_pixel(1'b1, 1'b0);
    offer_pixel(1'b1, 1'b1);
    offer_access(rlh_pkg::OP_READ, 8'd0, 1'b1);
    offer_access(rlh_pkg::OP_READ, 8'd2, 1'b0);
    offer_access(rlh_pkg::OP_READ, 8'd3, 1'b1);
    offer_access(rlh_pkg::OP_READ, 8'd1, 1'b0);
    offer_access(rlh_pkg::OP_CLEAR, 8'd0, 1'b1);
    offer_access(rlh_pkg::OP_READ, 8'd0, 1'b1);
    offer(OP_UNUSED, 1'b1, 1'b1, 8'd255, 1'b1);
    offer_pixel(1'b0, 1'b0);
    offer_access(rlh_pkg::OP_READ, 8'd1, 1'b0);
    offer_access(rlh_pkg::OP_CLEAR, 8'd1, 1'b0);
    offer_access(rlh_pkg::OP_READ, 8'd1, 1'b0);
    offer_access(rlh_pkg::OP_READ, 8'd255, 1'b0);
    settle();

    // Only the three lowest bins count.
    write_bins(9'd3);
    random_rows(80, 24);
    settle();

    // No bins in use: nothing is counted.
    write_bins(9'd0);
    random_rows(40, 24);
    settle();

    // One bin: only zero-length OFF runs from rows that start with a one.
    write_bins(9'd1);
    random_rows(40, 12);
    settle();

    // Full range with no idling on either side: an ON run and an OFF run back to
    // back, read right after they close.
    write_bins(9'd256);
    calm = 1'b1;
    offer_pixel(1'b1, 1'b1);
    offer_run(1'b1, 20);
    offer_pixel(1'b0, 1'b0);
    offer_run(1'b0, 9);
    offer_pixel(1'b1, 1'b0);
    offer_access(rlh_pkg::OP_READ, 8'd21, 1'b0);
    offer_access(rlh_pkg::OP_READ, 8'd10, 1'b1);
    offer_access(rlh_pkg::OP_READ, 8'd0, 1'b1);
    random_rows(60, 40);
    calm = 1'b0;
    settle();

    // Long receiver hold-off while reads keep coming, so the input backs up.
    hold_request = 1'b1;
    repeat (40) offer_access(rlh_pkg::OP_READ, 8'($urandom_range(15)), 1'($urandom_range(1)));
    settle();

    // Random bin count for the last stretch.
    write_bins(9'($urandom_range(255, 2)));
    random_rows(60, 60);
    settle();

    if (mismatch_total == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
